// ===== sv/byte_stream_tokenizer_assert.svh =====
// Assertion macros for the byte stream tokenizer RTL.
// Assumes the including module has clk_i and an active-low reset rst_ni.
`ifndef BYTE_STREAM_TOKENIZER_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tokenizer assertion failed");
// condition must never be true outside reset
`define BST_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tokenizer assertion failed");
`else
`define BST_ASSERT(lbl, prop)
`define BST_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== sv/bst_pkg.sv =====
// Shared types, constants and keyword tables for the byte stream tokenizer.
// No dependencies; imported by every tokenizer module.
package bst_pkg;

  // token buffer size and derived counter width (at least 6 for the length field)
  localparam int TokBufBytes = 64;
  localparam int CntRaw      = $clog2(TokBufBytes + 1);
  localparam int CntW        = (CntRaw > 6) ? CntRaw : 6;

  localparam int NumW   = 63;
  localparam int LineW  = 32;
  localparam int KwNum  = 12;

  localparam logic [NumW-1:0] NumMax = '1;

  // result queue geometry
  localparam int RqDepth = 4;
  localparam int RqPtrW  = $clog2(RqDepth);
  localparam int RqCntW  = $clog2(RqDepth + 1);

  // character codes
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChQuote   = 8'h22;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_HALT
  } mode_e;

  typedef enum logic [3:0] {
    KIND_TEXT    = 4'd0,
    KIND_OPEN    = 4'd1,
    KIND_CLOSE   = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_NUMBER  = 4'd4,
    KIND_IDENT   = 4'd5,
    KIND_KEYWORD = 4'd6,
    KIND_END     = 4'd7,
    KIND_ERROR   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_CHAR   = 2'd0,
    ERR_STR_LONG   = 2'd1,
    ERR_TOK_LONG   = 2'd2,
    ERR_UNTERM_STR = 2'd3
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        char_value;
    logic [3:0]        keyword_index;
    logic [NumW-1:0]   number_value;
    logic [5:0]        token_length;
    logic [LineW-1:0]  line_number;
    err_e              error_code;
    logic              last;
  } res_t;

  // up to two results produced by one input transaction
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } scan_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // keyword text, left aligned, zero padded
  function automatic logic [47:0] kw_text(input logic [3:0] idx);
    logic [47:0] t;
    unique case (idx)
      4'd0:    t = "define";
      4'd1:    t = {"func", 16'h0};
      4'd2:    t = {"block", 8'h0};
      4'd3:    t = {"begin", 8'h0};
      4'd4:    t = {"match", 8'h0};
      4'd5:    t = "switch";
      4'd6:    t = "branch";
      4'd7:    t = {"case", 16'h0};
      4'd8:    t = {"else", 16'h0};
      4'd9:    t = {"set", 24'h0};
      4'd10:   t = "return";
      4'd11:   t = {"goto", 16'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] idx);
    logic [2:0] l;
    unique case (idx)
      4'd0, 4'd5, 4'd6, 4'd10:    l = 3'd6;
      4'd1, 4'd7, 4'd8, 4'd11:    l = 3'd4;
      4'd2, 4'd3, 4'd4:           l = 3'd5;
      4'd9:                       l = 3'd3;
      default:                    l = 3'd0;
    endcase
    return l;
  endfunction

  // keyword idx has character c at position pos
  function automatic logic kw_match(input logic [3:0] idx, input logic [CntW-1:0] pos,
                                    input logic [7:0] c);
    logic [47:0] txt;
    logic [7:0]  ch;
    txt = kw_text(idx);
    case (pos[2:0])
      3'd0:    ch = txt[47:40];
      3'd1:    ch = txt[39:32];
      3'd2:    ch = txt[31:24];
      3'd3:    ch = txt[23:16];
      3'd4:    ch = txt[15:8];
      3'd5:    ch = txt[7:0];
      default: ch = '0;
    endcase
    return (pos < CntW'(kw_len(idx))) && (ch == c);
  endfunction

  function automatic res_t make_res(input kind_e kind, input logic [7:0] ch,
                                    input logic [3:0] kw, input logic [NumW-1:0] num,
                                    input logic [5:0] len, input logic [LineW-1:0] line,
                                    input err_e err);
    res_t r;
    r.kind          = kind;
    r.char_value    = ch;
    r.keyword_index = kw;
    r.number_value  = num;
    r.token_length  = len;
    r.line_number   = line;
    r.error_code    = err;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/bst_scan.sv =====
// Scanner state and per-byte token logic: one registered byte in, up to two results out.
// Depends on bst_pkg and byte_stream_tokenizer_assert.svh.
`include "byte_stream_tokenizer_assert.svh"

module bst_scan import bst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [7:0]  byte_i,
  input  logic        end_i,
  output scan_out_t   out_o
);

  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [NumW-1:0]   acc_q, acc_d;
  logic [KwNum-1:0]  mask_q, mask_d;
  logic [LineW-1:0]  line_q, line_d;

  logic [CntW-1:0]   cnt_inc;
  logic              too_long;
  logic [LineW-1:0]  line_inc;
  logic              c_digit, c_alpha, c_alnum;
  logic [NumW+3:0]   acc_sum;
  logic [NumW-1:0]   acc_next;
  logic [KwNum-1:0]  mask_run, mask_first;
  logic              kw_found;
  logic [3:0]        kw_idx;

  // between-token handling of the current byte
  logic              b_emit;
  res_t              b_res;
  mode_e             b_mode;
  logic [CntW-1:0]   b_count;
  logic [NumW-1:0]   b_acc;
  logic [KwNum-1:0]  b_mask;
  logic [LineW-1:0]  b_line;

  logic [1:0]        n;
  res_t              r0, r1;

  // shared datapath terms
  assign cnt_inc  = count_q + 1'b1;
  assign too_long = cnt_inc >= CntW'(TokBufBytes);
  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
  assign c_digit  = is_digit(byte_i);
  assign c_alpha  = is_alpha(byte_i);
  assign c_alnum  = !end_i && (c_digit || c_alpha);

  // acc * 10 + digit, saturating; low nibble of '0'..'9' is the digit value
  assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (NumW+4)'(byte_i[3:0]);
  assign acc_next = (|acc_sum[NumW+3:NumW]) ? NumMax : acc_sum[NumW-1:0];

  // keyword match mask update
  always_comb begin
    for (int i = 0; i < KwNum; i++) begin
      mask_run[i]   = mask_q[i] & kw_match(4'(i), count_q, byte_i);
      mask_first[i] = kw_match(4'(i), '0, byte_i);
    end
  end

  // first surviving keyword whose length equals the token length
  always_comb begin
    kw_found = 1'b0;
    kw_idx   = '0;
    for (int i = 0; i < KwNum; i++) begin
      if (!kw_found && mask_q[i] && (CntW'(kw_len(4'(i))) == count_q)) begin
        kw_found = 1'b1;
        kw_idx   = 4'(i);
      end
    end
  end

  // byte seen between tokens
  always_comb begin
    b_emit  = 1'b0;
    b_res   = make_res(KIND_TEXT, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    b_mode  = MODE_IDLE;
    b_count = count_q;
    b_acc   = acc_q;
    b_mask  = mask_q;
    b_line  = line_q;
    if (end_i) begin
      b_emit = 1'b1;
      b_res  = make_res(KIND_END, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    end else if (byte_i == ChSpace) begin
      b_mode = MODE_IDLE;
    end else if (byte_i == ChNewline) begin
      b_line = line_inc;
    end else if (byte_i == ChHash) begin
      b_mode = MODE_COMMENT;
    end else if (byte_i == ChOpen) begin
      b_emit = 1'b1;
      b_res  = make_res(KIND_OPEN, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    end else if (byte_i == ChClose) begin
      b_emit = 1'b1;
      b_res  = make_res(KIND_CLOSE, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    end else if (byte_i == ChQuote) begin
      b_mode  = MODE_STRING;
      b_count = '0;
    end else if (c_digit) begin
      b_mode  = MODE_NUMBER;
      b_acc   = NumW'(byte_i[3:0]);
      b_count = CntW'(1);
    end else if (c_alpha) begin
      b_mode  = MODE_IDENT;
      b_mask  = mask_first;
      b_count = CntW'(1);
      b_emit  = 1'b1;
      b_res   = make_res(KIND_TEXT, byte_i, '0, '0, '0, line_q, ERR_BAD_CHAR);
    end else begin
      b_mode = MODE_HALT;
      b_emit = 1'b1;
      b_res  = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    acc_d   = acc_q;
    mask_d  = mask_q;
    line_d  = line_q;
    unique case (mode_q)
      MODE_IDLE: begin
        mode_d  = b_mode;
        count_d = b_count;
        acc_d   = b_acc;
        mask_d  = b_mask;
        line_d  = b_line;
      end
      MODE_COMMENT: begin
        if (end_i) begin
          mode_d = MODE_IDLE;
        end else if (byte_i == ChNewline) begin
          line_d = line_inc;
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (end_i) begin
          mode_d = MODE_HALT;
        end else if (byte_i == ChQuote) begin
          mode_d = MODE_IDLE;
        end else begin
          count_d = cnt_inc;
          if (too_long) mode_d = MODE_HALT;
        end
      end
      MODE_NUMBER: begin
        if (!end_i && c_digit) begin
          acc_d   = acc_next;
          count_d = cnt_inc;
          if (too_long) mode_d = MODE_HALT;
        end else if (!end_i && c_alpha) begin
          mode_d = MODE_HALT;
        end else begin
          mode_d  = b_mode;
          count_d = b_count;
          acc_d   = b_acc;
          mask_d  = b_mask;
          line_d  = b_line;
        end
      end
      MODE_IDENT: begin
        if (c_alnum) begin
          mask_d  = mask_run;
          count_d = cnt_inc;
          if (too_long) mode_d = MODE_HALT;
        end else begin
          mode_d  = b_mode;
          count_d = b_count;
          acc_d   = b_acc;
          mask_d  = b_mask;
          line_d  = b_line;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  // results of this transaction
  always_comb begin
    n  = 2'd0;
    r0 = make_res(KIND_TEXT, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
    r1 = r0;
    unique case (mode_q)
      MODE_IDLE: begin
        n  = {1'b0, b_emit};
        r0 = b_res;
      end
      MODE_COMMENT: begin
        if (end_i) begin
          n  = 2'd1;
          r0 = make_res(KIND_END, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
        end
      end
      MODE_STRING: begin
        if (end_i) begin
          n  = 2'd1;
          r0 = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_UNTERM_STR);
        end else if (byte_i == ChQuote) begin
          n  = 2'd1;
          r0 = make_res(KIND_STRING, '0, '0, '0, count_q[5:0], line_q, ERR_BAD_CHAR);
        end else begin
          n  = too_long ? 2'd2 : 2'd1;
          r0 = make_res(KIND_TEXT, byte_i, '0, '0, '0, line_q, ERR_BAD_CHAR);
          r1 = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_STR_LONG);
        end
      end
      MODE_NUMBER: begin
        if (!end_i && c_digit) begin
          n  = too_long ? 2'd1 : 2'd0;
          r0 = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_TOK_LONG);
        end else if (!end_i && c_alpha) begin
          n  = 2'd1;
          r0 = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_BAD_CHAR);
        end else begin
          n  = b_emit ? 2'd2 : 2'd1;
          r0 = make_res(KIND_NUMBER, '0, '0, acc_q, '0, line_q, ERR_BAD_CHAR);
          r1 = b_res;
        end
      end
      MODE_IDENT: begin
        if (c_alnum) begin
          n  = too_long ? 2'd2 : 2'd1;
          r0 = make_res(KIND_TEXT, byte_i, '0, '0, '0, line_q, ERR_BAD_CHAR);
          r1 = make_res(KIND_ERROR, '0, '0, '0, '0, line_q, ERR_TOK_LONG);
        end else begin
          n  = b_emit ? 2'd2 : 2'd1;
          if (kw_found) begin
            r0 = make_res(KIND_KEYWORD, '0, kw_idx, '0, count_q[5:0], line_q, ERR_BAD_CHAR);
          end else begin
            r0 = make_res(KIND_IDENT, '0, '0, '0, count_q[5:0], line_q, ERR_BAD_CHAR);
          end
          r1 = b_res;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    // flag the final result of the transaction
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  assign out_o.n  = adv_i ? n : 2'd0;
  assign out_o.r0 = r0;
  assign out_o.r1 = r1;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      acc_q   <= '0;
      mask_q  <= '1;
      line_q  <= LineW'(1);
    end else if (adv_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      mask_q  <= mask_d;
      line_q  <= line_d;
    end
  end

  `BST_ASSERT(a_halt_sticky, (mode_q == MODE_HALT) |=> (mode_q == MODE_HALT))
  `BST_ASSERT(a_halt_silent, (mode_q == MODE_HALT) |-> (out_o.n == 2'd0))
  `BST_ASSERT(a_line_nonzero, line_q != '0)
  `BST_ASSERT_NEVER(a_two_only, out_o.n == 2'd3)

endmodule

// ===== sv/bst_resq.sv =====
// Small result queue: up to two results in a cycle, one out unless stalled.
// Depends on bst_pkg and byte_stream_tokenizer_assert.svh.
`include "byte_stream_tokenizer_assert.svh"

module bst_resq import bst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_out_t  push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       head_o
);

  res_t               mem_q [RqDepth];
  logic [RqPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [RqCntW-1:0]  count_q;
  logic               pop;
  logic [RqPtrW-1:0]  wr_ptr_p1;

  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a worst-case transaction, judged from the registered count only
  assign room_o      = count_q <= RqCntW'(RqDepth - 2);
  assign wr_ptr_p1   = wr_ptr_q + 1'b1;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_p1] <= push_i.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RqPtrW'(push_i.n);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q  <= count_q + RqCntW'(push_i.n) - RqCntW'(pop);
    end
  end

  `BST_ASSERT_NEVER(a_rq_overflow, (push_i.n != 2'd0) && !room_o)
  `BST_ASSERT(a_rq_count_max, count_q <= RqCntW'(RqDepth))
  `BST_ASSERT(a_rq_hold, (!out_valid_o && (push_i.n == 2'd0)) |=> !out_valid_o)

endmodule

// ===== sv/byte_stream_tokenizer.sv =====
// Top level of the byte stream tokenizer: input register, scanner and result queue.
// Depends on bst_pkg, bst_scan and bst_resq.
//
//   channel   signals                          direction   payload
//   in        in_valid_i / in_stall_o          to block    byte_req_i, is_end_i
//   out       out_valid_o / out_stall_i        from block  result_kind_o .. last_o
//
// One byte per cycle is taken while in_stall_o is low; a byte yielding two results
// (token end then a paren, end marker or error, or text echo then overlength error)
// fills two queue entries. Path: input register, scanner logic, result queue.
// in_stall_o rises when the input register is full and the four-entry result queue
// has fewer than two free entries. Reset is asynchronous: scanner between tokens,
// line count one, queue empty. After an error no further results are produced.

module byte_stream_tokenizer import bst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        byte_req_i,
  input  logic              is_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        result_kind_o,
  output logic [7:0]        char_value_o,
  output logic [3:0]        keyword_index_o,
  output logic [NumW-1:0]   number_value_o,
  output logic [5:0]        token_length_o,
  output logic [LineW-1:0]  line_number_o,
  output logic [1:0]        error_code_o,
  output logic              last_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       room;
  logic       adv;
  scan_out_t  scan_out;
  res_t       head;

  // input register
  assign adv        = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_req_i;
      end_q  <= is_end_i;
    end
  end

  bst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (byte_q),
    .end_i  (end_q),
    .out_o  (scan_out)
  );

  bst_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (scan_out),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  // result fields
  assign result_kind_o   = head.kind;
  assign char_value_o    = head.char_value;
  assign keyword_index_o = head.keyword_index;
  assign number_value_o  = head.number_value;
  assign token_length_o  = head.token_length;
  assign line_number_o   = head.line_number;
  assign error_code_o    = head.error_code;
  assign last_o          = head.last;

endmodule
